@@ design/iat_pkg.sv @@
// Shared types, codes and widths for the indexed array table.
package iat_pkg;

   // Built number of slots. The index and count widths below follow from it.
   localparam int DEPTH = 64;

   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int POS_W  = 8;
   localparam int CAP_W  = 7;
   localparam int STAT_W = 2;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Common width for comparing positions, counts and the capacity.
   localparam int CMP_A = (POS_W > CNT_W) ? POS_W : CNT_W;
   localparam int CMP_W = ((CMP_A > CAP_W) ? CMP_A : CAP_W) + 1;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OP_W-1:0] OP_GET    = 3'd4;
   localparam logic [OP_W-1:0] OP_SET    = 3'd5;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STAT_W-1:0] ST_MISS   = 2'd3;

   // Commands broadcast to every cell of the chain.
   localparam int CELL_OP_W = 3;
   localparam logic [CELL_OP_W-1:0] CELL_IDLE   = 3'd0;
   localparam logic [CELL_OP_W-1:0] CELL_INSERT = 3'd1;
   localparam logic [CELL_OP_W-1:0] CELL_DELETE = 3'd2;
   localparam logic [CELL_OP_W-1:0] CELL_WRITE  = 3'd3;
   localparam logic [CELL_OP_W-1:0] CELL_SWAP   = 3'd4;
   localparam logic [CELL_OP_W-1:0] CELL_LOAD   = 3'd5;
   localparam logic [CELL_OP_W-1:0] CELL_SHIFT  = 3'd6;

   typedef struct packed {
      logic [CELL_OP_W-1:0] op;
      logic [CMP_W-1:0]     pos;
      logic [CMP_W-1:0]     cnt;
      logic [DATA_W-1:0]    value;
   } cell_cmd_type;

endpackage

@@ design/indexed_array_table_core.sv @@
// Top level of the indexed array table: sequencer plus a chain of slot cells.
//
// A bounded list of signed 32-bit elements with a fill count. Each request item
// on the req_ channel (operation, position, value_in) gives exactly one result
// item on the rsp_ channel (status, read_value, found_index, fill_count).
// Insert, append, delete and set act on all slot cells at once: the result is
// valid in the cycle after the item is accepted, and such items can be taken
// in every cycle while the result side does not stall.
// Get and search load a read chain from the slots and shift it one slot a cycle
// toward slot 0, where a single comparator looks at it. No new item is taken
// until a get or search is done; that shift chain sets the worst-case rate.
// A search hit swaps the found entry with slot 0 in its last cycle.
// The capacity register is written through csr_write_enable/csr_write_data;
// write it only while no item is in work.
// Synchronous reset empties the list, sets capacity to 64 and drops any pending
// result. While rsp_stall holds a result, the result register keeps it and
// req_stall stays high; the element slots themselves are not cleared by reset.
module indexed_array_table_core
   import iat_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [POS_W-1:0]    req_position,
   input  logic [DATA_W-1:0]   req_value_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [DATA_W-1:0]   rsp_read_value,
   output logic [IDX_W-1:0]    rsp_found_index,
   output logic [CNT_W-1:0]    rsp_fill_count,
   input  logic                csr_write_enable,
   input  logic [CAP_W-1:0]    csr_write_data
);

   cell_cmd_type       cmd;
   logic [DATA_W-1:0]  slot_q [DEPTH];
   logic [DATA_W-1:0]  rd_q   [DEPTH];

   iat_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_position     (req_position),
      .req_value_in     (req_value_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_found_index  (rsp_found_index),
      .rsp_fill_count   (rsp_fill_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_rd          (rd_q[0]),
      .cmd              (cmd)
   );

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] left_w, right_w, right_rd_w;

      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid
         assign left_w = slot_q[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_w    = '0;
         assign right_rd_w = '0;
      end else begin : g_inner
         assign right_w    = slot_q[g+1];
         assign right_rd_w = rd_q[g+1];
      end

      iat_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .idx        (IDX_W'(g)),
         .left_slot  (left_w),
         .right_slot (right_w),
         .right_rd   (right_rd_w),
         .head_slot  (slot_q[0]),
         .slot       (slot_q[g]),
         .rd         (rd_q[g])
      );
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CMP_W'(rsp_fill_count) <= CMP_W'(DEPTH)))
      else $error("fill count beyond the built depth");

   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_MISS) |-> (rsp_found_index == '0))
      else $error("search miss reports a nonzero index");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("item taken while a result is held");

endmodule

@@ design/iat_cell.sv @@
// One slot of the list chain: stored element plus a read stage that shifts toward slot 0.
module iat_cell
   import iat_pkg::*;
(
   input  logic                clock,
   input  cell_cmd_type        cmd,
   input  logic [IDX_W-1:0]    idx,
   input  logic [DATA_W-1:0]   left_slot,
   input  logic [DATA_W-1:0]   right_slot,
   input  logic [DATA_W-1:0]   right_rd,
   input  logic [DATA_W-1:0]   head_slot,
   output logic [DATA_W-1:0]   slot,
   output logic [DATA_W-1:0]   rd
);

   logic [DATA_W-1:0] slot_ff, slot_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   logic [CMP_W-1:0]  my_idx;

   assign my_idx = CMP_W'(idx);

   always_comb begin
      slot_in = slot_ff;
      rd_in   = rd_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (my_idx == cmd.pos) begin
               slot_in = cmd.value;
            end else if (my_idx > cmd.pos && my_idx <= cmd.cnt) begin
               slot_in = left_slot;
            end
         end
         CELL_DELETE: begin
            if (my_idx >= cmd.pos && (my_idx + 1'b1) < cmd.cnt) begin
               slot_in = right_slot;
            end
         end
         CELL_WRITE: begin
            if (my_idx == cmd.pos) begin
               slot_in = cmd.value;
            end
         end
         CELL_SWAP: begin
            // The hit entry equals the key, so slot 0 simply takes the key.
            if (my_idx == '0) begin
               slot_in = cmd.value;
            end else if (my_idx == cmd.pos) begin
               slot_in = head_slot;
            end
         end
         CELL_LOAD: begin
            rd_in = slot_ff;
         end
         CELL_SHIFT: begin
            rd_in = right_rd;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      rd_ff   <= rd_in;
   end

   assign slot = slot_ff;
   assign rd   = rd_ff;

endmodule

@@ design/iat_ctrl.sv @@
// Request sequencer, fill count, capacity register and result register.
module iat_ctrl
   import iat_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [POS_W-1:0]    req_position,
   input  logic [DATA_W-1:0]   req_value_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [DATA_W-1:0]   rsp_read_value,
   output logic [IDX_W-1:0]    rsp_found_index,
   output logic [CNT_W-1:0]    rsp_fill_count,
   input  logic                csr_write_enable,
   input  logic [CAP_W-1:0]    csr_write_data,
   input  logic [DATA_W-1:0]   head_rd,
   output cell_cmd_type        cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   logic                state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CAP_W-1:0]    capacity_ff, capacity_in;
   logic [DATA_W-1:0]   key_ff, key_in;
   logic [POS_W-1:0]    target_ff, target_in;
   logic                get_mode_ff, get_mode_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [DATA_W-1:0]   read_ff, read_in;
   logic [IDX_W-1:0]    found_ff, found_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;

   logic                out_free, accept, finish;
   logic [CMP_W-1:0]    cap_w, limit_w, pos_w, cnt_w, scan_w;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign cap_w   = CMP_W'(capacity_ff);
   assign limit_w = (cap_w > DEPTH_C) ? DEPTH_C : cap_w;
   assign pos_w   = CMP_W'(req_position);
   assign cnt_w   = CMP_W'(count_ff);
   assign scan_w  = CMP_W'(scan_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      capacity_in = csr_write_enable ? csr_write_data : capacity_ff;
      key_in      = key_ff;
      target_in   = target_ff;
      get_mode_in = get_mode_ff;
      scan_in     = scan_ff;
      finish      = 1'b0;
      status_in   = ST_OK;
      read_in     = '0;
      found_in    = '0;
      fill_in     = count_ff;
      cmd         = '{op: CELL_IDLE, pos: pos_w, cnt: cnt_w, value: req_value_in};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               finish = 1'b1;
               unique case (req_operation)
                  OP_INSERT: begin
                     if (pos_w > cnt_w) begin
                        status_in = ST_BADPOS;
                     end else if (cnt_w >= limit_w) begin
                        status_in = ST_FULL;
                     end else begin
                        cmd.op   = CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_APPEND: begin
                     if (cnt_w >= limit_w) begin
                        status_in = ST_FULL;
                     end else begin
                        cmd.op   = CELL_WRITE;
                        cmd.pos  = cnt_w;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     if (pos_w >= cnt_w) begin
                        status_in = ST_BADPOS;
                     end else begin
                        cmd.op   = CELL_DELETE;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = ST_MISS;
                     end else begin
                        finish      = 1'b0;
                        cmd.op      = CELL_LOAD;
                        state_in    = S_SCAN;
                        get_mode_in = 1'b0;
                        scan_in     = '0;
                     end
                  end
                  OP_GET: begin
                     if (pos_w >= cnt_w) begin
                        status_in = ST_BADPOS;
                        read_in   = '1;
                     end else begin
                        finish      = 1'b0;
                        cmd.op      = CELL_LOAD;
                        state_in    = S_SCAN;
                        get_mode_in = 1'b1;
                        scan_in     = '0;
                     end
                  end
                  OP_SET: begin
                     if (pos_w >= cnt_w) begin
                        status_in = ST_BADPOS;
                     end else begin
                        cmd.op = CELL_WRITE;
                     end
                  end
                  default: begin
                  end
               endcase
               if (!finish) begin
                  key_in    = req_value_in;
                  target_in = req_position;
               end
            end
         end
         S_SCAN: begin
            // The read chain presents slot scan_ff at its head in this cycle.
            cmd.value = key_ff;
            cmd.pos   = scan_w;
            if (get_mode_ff) begin
               if (scan_w == CMP_W'(target_ff)) begin
                  if (out_free) begin
                     finish   = 1'b1;
                     read_in  = head_rd;
                     state_in = S_IDLE;
                  end
               end else begin
                  cmd.op  = CELL_SHIFT;
                  scan_in = scan_ff + 1'b1;
               end
            end else if (head_rd == key_ff) begin
               if (out_free) begin
                  finish   = 1'b1;
                  found_in = scan_ff;
                  cmd.op   = CELL_SWAP;
                  state_in = S_IDLE;
               end
            end else if ((scan_w + 1'b1) >= cnt_w) begin
               if (out_free) begin
                  finish    = 1'b1;
                  status_in = ST_MISS;
                  state_in  = S_IDLE;
               end
            end else begin
               cmd.op  = CELL_SHIFT;
               scan_in = scan_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      fill_in      = count_in;
      rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAP_W'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      target_ff   <= target_in;
      get_mode_ff <= get_mode_in;
      scan_ff     <= scan_in;
      if (finish) begin
         status_ff <= status_in;
         read_ff   <= read_in;
         found_ff  <= found_in;
         fill_ff   <= fill_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_read_value  = read_ff;
   assign rsp_found_index = found_ff;
   assign rsp_fill_count  = fill_ff;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the indexed array table core.
module tb_top
   import iat_pkg::*;
();

   localparam logic [OP_W-1:0] OP_UNUSED6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 70;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] read_value;
      logic [IDX_W-1:0]  found_index;
      logic [CNT_W-1:0]  fill_count;
   } table_result_type;

   class list_scoreboard_type;
      logic [DATA_W-1:0] slots [DEPTH];
      int count;
      int capacity;
      int mismatches;
      table_result_type owed_responses[$];

      function new();
         foreach (slots[i]) slots[i] = '0;
         count = 0;
         capacity = 64;
         mismatches = 0;
      endfunction

      function int pending();
         return owed_responses.size();
      endfunction

      // Applies one accepted request to the shadow list and queues its response.
      function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [DATA_W-1:0] val);
         table_result_type r;
         int limit;
         int i;
         logic [DATA_W-1:0] held;
         logic hit;
         r = '0;
         limit = (capacity > DEPTH) ? DEPTH : capacity;
         case (op)
            OP_INSERT: begin
               // A bad position wins over a full list.
               if (pos > count) r.status = ST_BADPOS;
               else if (count >= limit) r.status = ST_FULL;
               else begin
                  for (i = count; i > pos; i--) slots[i] = slots[i-1];
                  slots[pos] = val;
                  count++;
               end
            end
            OP_APPEND: begin
               if (count >= limit) r.status = ST_FULL;
               else begin
                  slots[count] = val;
                  count++;
               end
            end
            OP_DELETE: begin
               if (pos >= count) r.status = ST_BADPOS;
               else begin
                  for (i = pos; i + 1 < count; i++) slots[i] = slots[i+1];
                  count--;
               end
            end
            OP_SEARCH: begin
               r.status = ST_MISS;
               hit = 1'b0;
               for (i = 0; i < count; i++) begin
                  if (!hit && slots[i] == val) begin
                     hit = 1'b1;
                     held = slots[i];
                     slots[i] = slots[0];
                     slots[0] = held;
                     r.found_index = IDX_W'(i);
                     r.status = ST_OK;
                  end
               end
            end
            OP_GET: begin
               if (pos >= count) begin
                  r.status = ST_BADPOS;
                  r.read_value = '1;
               end else begin
                  r.read_value = slots[pos];
               end
            end
            OP_SET: begin
               if (pos >= count) r.status = ST_BADPOS;
               else slots[pos] = val;
            end
            default: ;
         endcase
         r.fill_count = CNT_W'(count);
         owed_responses.push_back(r);
      endfunction

      function void compare_response(table_result_type got);
         table_result_type want;
         if (owed_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: status %0d read %h index %0d fill %0d",
                        got.status, got.read_value, got.found_index, got.fill_count);
         end else begin
            want = owed_responses.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.found_index !== want.found_index ||
                got.fill_count !== want.fill_count) begin
               mismatches++;
               // Fields are status/read value/found index/fill count.
               if (mismatches <= MAX_REPORTS)
                  $display("response mismatch: want %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                           want.status, want.read_value, want.found_index,
                           want.fill_count, got.status, got.read_value,
                           got.found_index, got.fill_count);
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_operation = '0;
   logic [POS_W-1:0]  req_position = '0;
   logic [DATA_W-1:0] req_value_in = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [DATA_W-1:0] rsp_read_value;
   logic [IDX_W-1:0]  rsp_found_index;
   logic [CNT_W-1:0]  rsp_fill_count;
   logic              csr_write_enable = 1'b0;
   logic [CAP_W-1:0]  csr_write_data = '0;

   list_scoreboard_type sb = new();
   table_result_type    seen;
   logic           quiet = 1'b0;
   logic           hold_go = 1'b0;
   int             hold_left = 0;
   int             stall_left = 0;
   int             cycle_count = 0;

   indexed_array_table_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_position     (req_position),
      .req_value_in     (req_value_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_found_index  (rsp_found_index),
      .rsp_fill_count   (rsp_fill_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: short random stalls, a quiet stretch, and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(99) < 3) begin
            stall_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.status      = rsp_status;
         seen.read_value  = rsp_read_value;
         seen.found_index = rsp_found_index;
         seen.fill_count  = rsp_fill_count;
         sb.compare_response(seen);
      end
   end

   // Offers one request item, waits until it is taken, then maybe idles.
   task automatic offer(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                        input logic [DATA_W-1:0] val);
      int gap;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_position  <= pos;
      req_value_in  <= val;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, pos, val);
      if (!quiet && $urandom_range(99) < 3) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every owed response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input int value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= CAP_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.capacity = value;
   endtask

   // Mostly well-formed requests aimed at the current fill; some pure noise.
   task automatic random_phase(input int n, input int grow_pct);
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      int cnt;
      for (int k = 0; k < n; k++) begin
         cnt = sb.count;
         if ($urandom_range(99) < 10) begin
            op  = OP_W'($urandom_range(0, 7));
            pos = POS_W'($urandom_range(0, 255));
            val = $urandom();
         end else begin
            if ($urandom_range(99) < grow_pct) begin
               op = ($urandom_range(1) == 1) ? OP_APPEND : OP_INSERT;
            end else begin
               case ($urandom_range(0, 3))
                  0: op = OP_DELETE;
                  1: op = OP_SEARCH;
                  2: op = OP_GET;
                  default: op = OP_SET;
               endcase
            end
            pos = (cnt == 0) ? '0 : POS_W'($urandom_range(0, cnt - 1));
            if (op == OP_INSERT) pos = POS_W'($urandom_range(0, cnt));
            // Just past the end, to hit the boundary of every position check.
            if ($urandom_range(99) < 5)
               pos = (op == OP_INSERT) ? POS_W'(cnt + 1) : POS_W'(cnt);
            if ($urandom_range(1) == 1) val = $urandom();
            else val = DATA_W'($urandom_range(0, 15) - 8);
            if (op == OP_SEARCH && cnt > 0 && $urandom_range(99) < 70)
               val = sb.slots[$urandom_range(0, cnt - 1)];
         end
         offer(op, pos, val);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_capacity(3);
      offer(OP_SEARCH, 8'd0, 32'd0);
      offer(OP_GET, 8'd0, 32'd0);
      offer(OP_APPEND, 8'd0, 32'h7FFF_FFFF);
      offer(OP_INSERT, 8'd0, 32'h8000_0000);
      offer(OP_INSERT, 8'd2, 32'hFFFF_FFFF);
      offer(OP_APPEND, 8'd0, 32'd5);
      offer(OP_INSERT, 8'd1, 32'd6);
      offer(OP_INSERT, 8'hFF, 32'd7);
      offer(OP_DELETE, 8'd3, 32'd0);
      offer(OP_GET, 8'hFF, 32'd0);
      offer(OP_SET, 8'd3, 32'd1);
      offer(OP_SEARCH, 8'd0, 32'hFFFF_FFFF);
      offer(OP_GET, 8'd0, 32'd0);
      offer(OP_SEARCH, 8'd0, 32'd12345);
      offer(OP_SET, 8'd1, 32'd0);
      offer(OP_UNUSED6, 8'hAA, 32'h5555_5555);
      offer(OP_UNUSED7, 8'h55, 32'hAAAA_AAAA);
      offer(OP_DELETE, 8'd0, 32'd0);
      offer(OP_DELETE, 8'd1, 32'd0);
      offer(OP_INSERT, 8'd1, 32'd9);
      // Capacity now below the fill count: the entries stay, growth is refused.
      set_capacity(1);
      offer(OP_APPEND, 8'd0, 32'd1);
      offer(OP_DELETE, 8'd0, 32'd0);
      offer(OP_INSERT, 8'd0, 32'd2);
      set_capacity(0);
      offer(OP_DELETE, 8'd0, 32'd0);
      offer(OP_APPEND, 8'd0, 32'd3);

      set_capacity(64);
      quiet = 1'b1;
      random_phase(120, 55);
      quiet = 1'b0;
      set_capacity(8);
      random_phase(100, 50);
      set_capacity(127);
      hold_go = 1'b1;
      random_phase(80, 75);
      settle();
      random_phase(80, 40);
      set_capacity(1);
      random_phase(50, 50);
      set_capacity(16);
      random_phase(100, 50);
      set_capacity(2);
      random_phase(50, 50);
      set_capacity(64);
      random_phase(80, 45);
      set_capacity(5);
      random_phase(60, 30);

      settle();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
design/iat_pkg.sv
design/iat_cell.sv
design/iat_ctrl.sv
design/indexed_array_table_core.sv
bench/tb_top.sv
